@@ hdl/spas_pkg.sv @@
`timescale 1ns / 1ps

package spas_pkg;

  localparam int unsigned TERM_DEPTH = 32;
  localparam int unsigned LEN_W      = $clog2(TERM_DEPTH + 1);
  localparam int unsigned ADDR_W     = (TERM_DEPTH > 1) ? $clog2(TERM_DEPTH) : 1;
  localparam int unsigned EXPO_W     = 16;
  localparam int unsigned COEF_W     = 32;
  localparam int unsigned SUM_W      = COEF_W + 2;

  localparam logic signed [SUM_W-1:0] COEF_MAX = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] COEF_MIN = -SUM_W'(64'sd2147483648);

  typedef enum logic [1:0] {
    OP_LOAD_FIRST  = 2'd0,
    OP_LOAD_SECOND = 2'd1,
    OP_EMIT_SUM    = 2'd2,
    OP_EMIT_DIFF   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MERGE
  } state_e;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    logic signed [EXPO_W-1:0] expo;
  } term_t;

endpackage

@@ hdl/spas_ram.sv @@
`timescale 1ns / 1ps

module spas_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/sparse_polynomial_add_sub.sv @@
`timescale 1ns / 1ps

// sparse polynomial adder / subtractor
// input channel s_axis: tuser carries the opcode (load first, load second,
// emit sum, emit difference), tdata carries the term exponent and coefficient.
// a load request is taken while idle and appends the term to its store
// (32 terms each; terms must be loaded in descending exponent order, which the
// block does not enforce); a load into a full store is dropped and flagged on the next emitted run.
// an emit request merges both stores through one shared saturating adder:
// each merged term passes a fetch state (store read, set by the registered
// read of the term memories) and a merge state (compare and add).
// tready stays low for the whole emit; both stores and the drop flag clear
// once the last term is registered. an emit with both stores empty gives no
// output and returns to idle from the fetch state.
// output channel m_axis: tdata holds exponent and coefficient, tuser the
// saturated and dropped flags, tlast marks the final term of a run.
// results sit in an output register; while the receiver stalls, the merge
// waits and no term is lost. loads may be taken while a result still waits.
// reset empties both stores and clears the drop flag and the output valid flag.

module sparse_polynomial_add_sub
  import spas_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // term_exponent[15:0], term_coefficient[47:16]
  input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // out_exponent[15:0], out_coefficient[47:16]
  output logic [1:0]  m_axis_tuser,  // saturated[0], dropped_terms[1]
  output logic        m_axis_tlast   // last_term
);

  state_e state_q, state_d;

  logic [LEN_W-1:0] len1_q, len1_d, len2_q, len2_d;
  logic [LEN_W-1:0] i_q, i_d, j_q, j_d;
  logic             drop_q, drop_d;
  logic             diff_q, diff_d;

  logic  out_valid_q, out_valid_d;
  term_t out_term_q, out_term_d;
  logic  out_sat_q, out_sat_d;
  logic  out_drop_q, out_drop_d;
  logic  out_last_q, out_last_d;

  opcode_e in_op;
  term_t   in_term;
  logic    in_req;
  logic    is_load, is_emit;

  term_t t1, t2;
  logic  we1, we2;
  logic  have1, have2, take_both, take1, take2;
  logic  out_free, step, merge_last, finish;
  logic [LEN_W-1:0] i_next, j_next;

  logic signed [SUM_W-1:0] add_a, add_b, b_raw, sum;
  logic                    sat_hi, sat_lo;

  assign in_op   = opcode_e'(s_axis_tuser);
  assign in_term = term_t'(s_axis_tdata);
  assign in_req  = s_axis_tvalid && s_axis_tready;
  assign is_load = (in_op == OP_LOAD_FIRST) || (in_op == OP_LOAD_SECOND);
  assign is_emit = !is_load;

  assign we1 = in_req && (in_op == OP_LOAD_FIRST) && (len1_q < LEN_W'(TERM_DEPTH));
  assign we2 = in_req && (in_op == OP_LOAD_SECOND) && (len2_q < LEN_W'(TERM_DEPTH));

  spas_ram #(
    .WIDTH ($bits(term_t)),
    .DEPTH (TERM_DEPTH)
  ) u_first_store (
    .clk_i   (clk_i),
    .we_i    (we1),
    .waddr_i (len1_q[ADDR_W-1:0]),
    .wdata_i (in_term),
    .raddr_i (i_q[ADDR_W-1:0]),
    .rdata_o (t1)
  );

  spas_ram #(
    .WIDTH ($bits(term_t)),
    .DEPTH (TERM_DEPTH)
  ) u_second_store (
    .clk_i   (clk_i),
    .we_i    (we2),
    .waddr_i (len2_q[ADDR_W-1:0]),
    .wdata_i (in_term),
    .raddr_i (j_q[ADDR_W-1:0]),
    .rdata_o (t2)
  );

  // merge selection
  assign have1     = i_q < len1_q;
  assign have2     = j_q < len2_q;
  assign take_both = have1 && have2 && (t1.expo == t2.expo);
  assign take1     = !take_both && (!have2 || (have1 && (t1.expo > t2.expo)));
  assign take2     = !take_both && !take1;
  assign i_next    = (take1 || take_both) ? i_q + LEN_W'(1) : i_q;
  assign j_next    = (take2 || take_both) ? j_q + LEN_W'(1) : j_q;
  assign merge_last = (i_next >= len1_q) && (j_next >= len2_q);

  assign out_free = !out_valid_q || m_axis_tready;
  assign step     = (state_q == ST_MERGE) && out_free;
  assign finish   = ((state_q == ST_FETCH) && !have1 && !have2) || (step && merge_last);

  // shared saturating adder
  assign add_a  = take2 ? '0 : SUM_W'(t1.coef);
  assign b_raw  = take1 ? '0 : SUM_W'(t2.coef);
  assign add_b  = diff_q ? -b_raw : b_raw;
  assign sum    = add_a + add_b;
  assign sat_hi = sum > COEF_MAX;
  assign sat_lo = sum < COEF_MIN;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_req && is_emit) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_d = (have1 || have2) ? ST_MERGE : ST_IDLE;
      end
      ST_MERGE: begin
        if (step) begin
          state_d = merge_last ? ST_IDLE : ST_FETCH;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    len1_d      = len1_q;
    len2_d      = len2_q;
    i_d         = i_q;
    j_d         = j_q;
    drop_d      = drop_q;
    diff_d      = diff_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_term_d  = out_term_q;
    out_sat_d   = out_sat_q;
    out_drop_d  = out_drop_q;
    out_last_d  = out_last_q;

    if (we1) begin
      len1_d = len1_q + LEN_W'(1);
    end
    if (we2) begin
      len2_d = len2_q + LEN_W'(1);
    end
    if (in_req && is_load && !we1 && !we2) begin
      drop_d = 1'b1;
    end
    if (in_req && is_emit) begin
      i_d    = '0;
      j_d    = '0;
      diff_d = (in_op == OP_EMIT_DIFF);
    end

    if (step) begin
      i_d             = i_next;
      j_d             = j_next;
      out_valid_d     = 1'b1;
      out_term_d.expo = take2 ? t2.expo : t1.expo;
      if (sat_hi) begin
        out_term_d.coef = COEF_W'(COEF_MAX);
      end else if (sat_lo) begin
        out_term_d.coef = COEF_W'(COEF_MIN);
      end else begin
        out_term_d.coef = sum[COEF_W-1:0];
      end
      out_sat_d  = sat_hi || sat_lo;
      out_drop_d = drop_q;
      out_last_d = merge_last;
    end

    if (finish) begin
      len1_d = '0;
      len2_d = '0;
      drop_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len1_q      <= '0;
      len2_q      <= '0;
      i_q         <= '0;
      j_q         <= '0;
      drop_q      <= 1'b0;
      diff_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len1_q      <= len1_d;
      len2_q      <= len2_d;
      i_q         <= i_d;
      j_q         <= j_d;
      drop_q      <= drop_d;
      diff_q      <= diff_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_term_q <= out_term_d;
    out_sat_q  <= out_sat_d;
    out_drop_q <= out_drop_d;
    out_last_q <= out_last_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_term_q;
  assign m_axis_tuser  = {out_drop_q, out_sat_q};
  assign m_axis_tlast  = out_last_q;

  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len1_q <= LEN_W'(TERM_DEPTH)) && (len2_q <= LEN_W'(TERM_DEPTH)))
    else $error("store length beyond depth");

  a_index_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> ((i_q <= len1_q) && (j_q <= len2_q)))
    else $error("merge index beyond store length");

  a_clear_after_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && merge_last) |=> ((len1_q == '0) && (len2_q == '0) && !drop_q
                              && m_axis_tvalid && m_axis_tlast))
    else $error("stores not cleared after last term");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MERGE && out_valid_q && !m_axis_tready)
      |=> (state_q == ST_MERGE && i_q == $past(i_q) && j_q == $past(j_q)))
    else $error("merge advanced while result was stalled");

endmodule

@@ verif/sparse_polynomial_add_sub_tb.sv @@
`timescale 1ns / 1ps

module sparse_polynomial_add_sub_tb;
  import spas_pkg::*;

  typedef struct {
    logic signed [EXPO_W-1:0] expo;
    logic signed [COEF_W-1:0] coef;
    logic                     sat;
    logic                     dropped;
    logic                     last;
  } merged_term_t;

  class poly_merge_tracker;
    term_t        first_terms[TERM_DEPTH];
    term_t        second_terms[TERM_DEPTH];
    int unsigned  first_len;
    int unsigned  second_len;
    bit           drop_flag;
    merged_term_t expected_terms[$];
    int           error_count;

    function new();
      first_len   = 0;
      second_len  = 0;
      drop_flag   = 1'b0;
      error_count = 0;
    endfunction

    function void push_term(logic signed [EXPO_W-1:0] expo, longint value, bit last);
      merged_term_t t;
      t.expo = expo;
      t.sat  = 1'b0;
      if (value > longint'(COEF_MAX)) begin
        value = longint'(COEF_MAX);
        t.sat = 1'b1;
      end else if (value < longint'(COEF_MIN)) begin
        value = longint'(COEF_MIN);
        t.sat = 1'b1;
      end
      t.coef    = COEF_W'(value);
      t.dropped = drop_flag;
      t.last    = last;
      expected_terms.push_back(t);
    endfunction

    function void note_request(opcode_e op, logic signed [EXPO_W-1:0] term_expo,
                               logic signed [COEF_W-1:0] term_coef);
      int unsigned              i;
      int unsigned              j;
      longint                   a;
      longint                   b;
      bit                       from_first;
      bit                       from_second;
      logic signed [EXPO_W-1:0] e;
      i = 0;
      j = 0;
      if (op == OP_LOAD_FIRST) begin
        if (first_len < TERM_DEPTH) begin
          first_terms[first_len].expo = term_expo;
          first_terms[first_len].coef = term_coef;
          first_len++;
        end else begin
          drop_flag = 1'b1;
        end
        return;
      end
      if (op == OP_LOAD_SECOND) begin
        if (second_len < TERM_DEPTH) begin
          second_terms[second_len].expo = term_expo;
          second_terms[second_len].coef = term_coef;
          second_len++;
        end else begin
          drop_flag = 1'b1;
        end
        return;
      end
      // merge both heads; a tie combines, otherwise the larger exponent goes first
      while (i < first_len || j < second_len) begin
        from_first  = (i < first_len) && ((j >= second_len) ||
                      ($signed(first_terms[i].expo) >= $signed(second_terms[j].expo)));
        from_second = (j < second_len) && ((i >= first_len) ||
                      ($signed(second_terms[j].expo) >= $signed(first_terms[i].expo)));
        a = from_first ? longint'($signed(first_terms[i].coef)) : 64'sd0;
        b = from_second ? longint'($signed(second_terms[j].coef)) : 64'sd0;
        e = from_first ? first_terms[i].expo : second_terms[j].expo;
        if (from_first) i++;
        if (from_second) j++;
        push_term(e, (op == OP_EMIT_DIFF) ? a - b : a + b,
                  (i >= first_len) && (j >= second_len));
      end
      first_len  = 0;
      second_len = 0;
      drop_flag  = 1'b0;
    endfunction

    function void check_term(logic [47:0] data, logic [1:0] flags, logic last);
      merged_term_t t;
      if (expected_terms.size() == 0) begin
        $error("unexpected term: exponent %0d coefficient %0d",
               $signed(data[15:0]), $signed(data[47:16]));
        error_count++;
        return;
      end
      t = expected_terms.pop_front();
      if (data[15:0] !== t.expo) begin
        $error("out_exponent: expected %0d, actual %0d", t.expo, $signed(data[15:0]));
        error_count++;
      end
      if (data[47:16] !== t.coef) begin
        $error("out_coefficient: expected %0d, actual %0d", t.coef, $signed(data[47:16]));
        error_count++;
      end
      if (flags[0] !== t.sat) begin
        $error("saturated: expected %0b, actual %0b", t.sat, flags[0]);
        error_count++;
      end
      if (flags[1] !== t.dropped) begin
        $error("dropped_terms: expected %0b, actual %0b", t.dropped, flags[1]);
        error_count++;
      end
      if (last !== t.last) begin
        $error("last_term: expected %0b, actual %0b", t.last, last);
        error_count++;
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;  // term_exponent[15:0], term_coefficient[47:16]
  logic [1:0]  s_axis_tuser  = '0;  // opcode[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // out_exponent[15:0], out_coefficient[47:16]
  logic [1:0]  m_axis_tuser;        // saturated[0], dropped_terms[1]
  logic        m_axis_tlast;        // last_term

  poly_merge_tracker tracker;
  int items_sent    = 0;
  int results_seen  = 0;
  bit quiet_phase   = 1'b0;
  bit hold_off_done = 1'b0;

  always #4 clk_i = ~clk_i;

  sparse_polynomial_add_sub DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  function automatic logic [COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(0, 131072)) - 32'd65536;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [EXPO_W-1:0] rand_expo();
    return 16'($urandom);
  endfunction

  function automatic int rand_len();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return $urandom_range(0, 5);
    if (pick < 9) return $urandom_range(6, 12);
    return $urandom_range(28, 34);
  endfunction

  task automatic send_request(opcode_e op, logic signed [EXPO_W-1:0] term_expo,
                              logic signed [COEF_W-1:0] term_coef);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {term_coef, term_expo};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tracker.note_request(op, term_expo, term_coef);
    items_sent++;
    if (items_sent >= 330) quiet_phase = 1'b1;
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.check_term(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      results_seen <= results_seen + 1;
    end
  end

  initial begin : receiver
    int stall;
    forever begin
      @(posedge clk_i);
      stall = 0;
      if (!hold_off_done && results_seen >= 12) begin
        // long hold so the merge backs up and the input stalls
        stall = 400;
        hold_off_done = 1'b1;
      end else if (rst_ni && !quiet_phase && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 3);
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  initial begin : stimulus
    int      n_first;
    int      n_second;
    int      i;
    int      j;
    int      seq;
    int      kind;
    int      cur_first;
    int      cur_second;
    int      wait_cycles;
    bit      scrambled;
    opcode_e emit_op;
    tracker = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // emits with nothing loaded
    send_request(OP_EMIT_SUM, 16'sh1234, 32'sh5a5a_5a5a);
    send_request(OP_EMIT_DIFF, 16'sh8000, 32'sh8000_0000);
    // field extremes, sum saturation both ways
    send_request(OP_LOAD_FIRST, 16'sh7fff, 32'sh7fff_ffff);
    send_request(OP_LOAD_FIRST, 16'sh0000, 32'sh0001_0000);
    send_request(OP_LOAD_FIRST, 16'sh8000, 32'sh8000_0000);
    send_request(OP_LOAD_SECOND, 16'sh7fff, 32'sh7fff_ffff);
    send_request(OP_LOAD_SECOND, 16'sh0005, 32'sh8000_0000);
    send_request(OP_LOAD_SECOND, 16'sh8000, 32'sh8000_0000);
    send_request(OP_EMIT_SUM, 16'sh0000, 32'sh0000_0000);
    // difference: saturating subtract, negating the most negative value
    send_request(OP_LOAD_FIRST, 16'sh7fff, 32'sh8000_0000);
    send_request(OP_LOAD_FIRST, 16'sh0064, 32'shffff_0000);
    send_request(OP_LOAD_SECOND, 16'sh7fff, 32'sh7fff_ffff);
    send_request(OP_LOAD_SECOND, 16'sh0032, 32'sh8000_0000);
    send_request(OP_LOAD_SECOND, 16'shfffb, 32'sh1234_5678);
    send_request(OP_EMIT_DIFF, 16'sh7fff, 32'shffff_ffff);
    // unsorted stores, equal terms cancel to a kept zero
    send_request(OP_LOAD_FIRST, 16'sh0001, 32'sh0003_0000);
    send_request(OP_LOAD_FIRST, 16'sh0009, 32'shfffe_0000);
    send_request(OP_LOAD_SECOND, 16'sh0005, 32'sh0000_8000);
    send_request(OP_LOAD_SECOND, 16'sh0014, 32'shffff_ffff);
    send_request(OP_LOAD_SECOND, 16'sh0001, 32'sh0003_0000);
    send_request(OP_EMIT_DIFF, 16'sh0000, 32'sh0000_0000);

    seq = 0;
    while (items_sent < 380) begin
      kind = $urandom_range(0, 19);
      if (seq == 0 || kind < 17) begin
        scrambled  = (seq != 0) && (kind >= 14);
        // first pass overfills both stores
        n_first    = (seq == 0) ? 34 : (scrambled ? $urandom_range(1, 6) : rand_len());
        n_second   = (seq == 0) ? 33 : (scrambled ? $urandom_range(1, 6) : rand_len());
        cur_first  = ($urandom_range(0, 3) == 0) ? 32767 : int'($signed(rand_expo()));
        cur_second = cur_first;
        i = 0;
        j = 0;
        while (i < n_first || j < n_second) begin
          if (j >= n_second || (i < n_first && $urandom_range(0, 1) == 1)) begin
            send_request(OP_LOAD_FIRST,
                         scrambled ? 16'($urandom_range(0, 8)) - 16'd4 : 16'(cur_first),
                         rand_coef());
            cur_first = cur_first - int'($urandom_range(0, 2));
            if (cur_first < -32768) cur_first = -32768;
            i++;
          end else begin
            send_request(OP_LOAD_SECOND,
                         scrambled ? 16'($urandom_range(0, 8)) - 16'd4 : 16'(cur_second),
                         rand_coef());
            cur_second = cur_second - int'($urandom_range(0, 2));
            if (cur_second < -32768) cur_second = -32768;
            j++;
          end
        end
        emit_op = ($urandom_range(0, 1) == 1) ? OP_EMIT_DIFF : OP_EMIT_SUM;
        send_request(emit_op, rand_expo(), rand_coef());
      end else begin
        repeat ($urandom_range(1, 3)) begin
          send_request(opcode_e'($urandom_range(0, 3)), rand_expo(), rand_coef());
        end
      end
      seq++;
    end

    s_axis_tvalid <= 1'b0;
    wait_cycles = 0;
    while (tracker.expected_terms.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (20) @(posedge clk_i);
    if (tracker.expected_terms.size() != 0) begin
      $error("%0d expected terms never arrived", tracker.expected_terms.size());
      tracker.error_count++;
    end
    if (tracker.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
